>>> sv/efd_pkg.sv
package efd_pkg;

  // Payload store depth and derived widths
  localparam int unsigned MSG_BYTES = 64;
  localparam int unsigned ADDR_W    = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1;
  localparam int unsigned CNT_W     = $clog2(MSG_BYTES + 1);

  // Field widths of the channels
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned LEN_W  = 7;

  // Control characters on the line
  localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h5E;
  localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h24;
  localparam logic [BYTE_W-1:0] CH_ABORT = 8'h21;
  localparam logic [BYTE_W-1:0] CH_ESC   = 8'h5C;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD
  } efd_state_e;

  // Controller to datapath
  typedef struct packed {
    logic take_byte;
    logic rd_en;
    logic load_out;
  } efd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic close_hit;
    logic last_idx;
    logic out_free;
  } efd_sts_t;

endpackage

>>> sv/efd_rx_if.sv
interface efd_rx_if;
  import efd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> sv/efd_res_if.sv
interface efd_res_if;
  import efd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] payload_byte;
  logic [IDX_W-1:0]  byte_index;
  logic [LEN_W-1:0]  frame_length;
  logic              empty_frame;
  logic              last_in_frame;

  modport source (
    output valid, output payload_byte, output byte_index, output frame_length,
    output empty_frame, output last_in_frame, input ready
  );
  modport sink (
    input valid, input payload_byte, input byte_index, input frame_length,
    input empty_frame, input last_in_frame, output ready
  );
endinterface

>>> sv/efd_ctrl.sv
module efd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  efd_pkg::efd_sts_t sts_i,
  output efd_pkg::efd_cmd_t cmd_o
);
  import efd_pkg::*;

  efd_state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && sts_i.close_hit) state_d = ST_READ;
      end
      ST_READ: state_d = ST_LOAD;
      ST_LOAD: begin
        if (sts_i.out_free) state_d = sts_i.last_idx ? ST_IDLE : ST_READ;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o      = 1'b0;
    cmd_o.take_byte = 1'b0;
    cmd_o.rd_en     = 1'b0;
    cmd_o.load_out  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.take_byte = in_valid_i;
      end
      ST_READ: cmd_o.rd_en = 1'b1;
      ST_LOAD: cmd_o.load_out = sts_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_read_then_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |=> state_q == ST_LOAD)
    else $error("read not followed by load");

  a_close_starts_replay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.take_byte && sts_i.close_hit |=> state_q == ST_READ)
    else $error("close did not start replay");

  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == ST_IDLE)
    else $error("input ready during replay");

endmodule

>>> sv/efd_datapath.sv
module efd_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [efd_pkg::BYTE_W-1:0] rx_byte_i,
  input  efd_pkg::efd_cmd_t          cmd_i,
  output efd_pkg::efd_sts_t          sts_o,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic [efd_pkg::BYTE_W-1:0] payload_byte_o,
  output logic [efd_pkg::IDX_W-1:0]  byte_index_o,
  output logic [efd_pkg::LEN_W-1:0]  frame_length_o,
  output logic                       empty_frame_o,
  output logic                       last_in_frame_o
);
  import efd_pkg::*;

  logic              in_frame_q, in_frame_d;
  logic              esc_q, esc_d;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic [CNT_W-1:0]  len_q, len_d;
  logic [ADDR_W-1:0] rd_idx_q, rd_idx_d;
  logic              wr_en;
  logic [BYTE_W-1:0] wr_data;
  logic [BYTE_W-1:0] mem [MSG_BYTES];
  logic [BYTE_W-1:0] rdata_q;
  logic              out_valid_q;
  logic [BYTE_W-1:0] payload_q;
  logic [IDX_W-1:0]  index_q;
  logic [LEN_W-1:0]  length_q;
  logic              empty_q;
  logic              last_q;
  logic              len_zero;

  assign len_zero         = (len_q == '0);
  assign sts_o.close_hit  = (rx_byte_i == CH_CLOSE) && in_frame_q;
  assign sts_o.last_idx   = len_zero || ((CNT_W'(rd_idx_q) + CNT_W'(1)) == len_q);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  // Decode the received byte, or advance the read index on an output load
  always_comb begin
    in_frame_d = in_frame_q;
    esc_d      = esc_q;
    fill_d     = fill_q;
    len_d      = len_q;
    rd_idx_d   = rd_idx_q;
    wr_en      = 1'b0;
    wr_data    = esc_q ? ~rx_byte_i : rx_byte_i;
    if (cmd_i.take_byte) begin
      case (rx_byte_i)
        CH_OPEN: begin
          in_frame_d = 1'b1;
          esc_d      = 1'b0;
          fill_d     = '0;
        end
        CH_CLOSE: begin
          if (in_frame_q) begin
            in_frame_d = 1'b0;
            len_d      = fill_q;
            rd_idx_d   = '0;
          end
        end
        CH_ABORT: in_frame_d = 1'b0;
        CH_ESC:   esc_d = 1'b1;
        default: begin
          if (in_frame_q) begin
            if (fill_q == CNT_W'(MSG_BYTES)) begin
              // store full: drop the frame
              in_frame_d = 1'b0;
            end else begin
              wr_en  = 1'b1;
              esc_d  = 1'b0;
              fill_d = fill_q + CNT_W'(1);
            end
          end
        end
      endcase
    end else if (cmd_i.load_out) begin
      rd_idx_d = rd_idx_q + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      esc_q      <= 1'b0;
      fill_q     <= '0;
      len_q      <= '0;
      rd_idx_q   <= '0;
    end else begin
      in_frame_q <= in_frame_d;
      esc_q      <= esc_d;
      fill_q     <= fill_d;
      len_q      <= len_d;
      rd_idx_q   <= rd_idx_d;
    end
  end

  // Payload store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[fill_q[ADDR_W-1:0]] <= wr_data;
    if (cmd_i.rd_en) rdata_q <= mem[rd_idx_q];
  end

  // Output word valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output word payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      payload_q <= len_zero ? '0 : rdata_q;
      index_q   <= len_zero ? '0 : IDX_W'(rd_idx_q);
      length_q  <= LEN_W'(len_q);
      empty_q   <= len_zero;
      last_q    <= sts_o.last_idx;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign payload_byte_o  = payload_q;
  assign byte_index_o    = index_q;
  assign frame_length_o  = length_q;
  assign empty_frame_o   = empty_q;
  assign last_in_frame_o = last_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(MSG_BYTES))
    else $error("fill count past store depth");

  a_load_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || out_ready_i))
    else $error("output word overwritten");

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && empty_q |-> last_q)
    else $error("empty frame word not flagged last");

  a_no_take_in_replay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> !cmd_i.take_byte && !wr_en)
    else $error("byte taken during replay");

endmodule

>>> sv/escaped_frame_deframer.sv
// A data or control byte is absorbed in the cycle it is accepted.
// A closing '$' starts a replay: a read state registers the stored byte from the
// payload store, and a load state loads the output word once the output slot is free.
// Throughput: 1 byte per cycle while receiving; input is not ready during a replay.
// Reset (rst_ni low, asynchronous): no frame open, no escape pending, empty store.
module escaped_frame_deframer (
  input  logic  clk_i,
  input  logic  rst_ni,
  efd_rx_if.sink    rx_i,
  efd_res_if.source res_o
);
  import efd_pkg::*;

  efd_cmd_t cmd;
  efd_sts_t sts;

  efd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (rx_i.valid),
    .in_ready_o (rx_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  efd_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .rx_byte_i       (rx_i.rx_byte),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_ready_i     (res_o.ready),
    .out_valid_o     (res_o.valid),
    .payload_byte_o  (res_o.payload_byte),
    .byte_index_o    (res_o.byte_index),
    .frame_length_o  (res_o.frame_length),
    .empty_frame_o   (res_o.empty_frame),
    .last_in_frame_o (res_o.last_in_frame)
  );

endmodule

>>> tb/efd_checker.sv
module efd_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  efd_rx_if           rx_i,
  efd_res_if          res_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  import efd_pkg::*;

  // One replayed word as the result channel carries it
  typedef struct packed {
    logic [BYTE_W-1:0] payload;
    logic [IDX_W-1:0]  index;
    logic [LEN_W-1:0]  length;
    logic              empty;
    logic              last;
  } frame_word_t;

  // Shadow of the deframer state
  logic              line_open;
  logic              escape_armed;
  logic [CNT_W-1:0]  stored_len;
  logic [BYTE_W-1:0] payload_mem [MSG_BYTES];

  // Words the block still owes, oldest first
  frame_word_t replay_q [$];

  // Advance the shadow state by one received byte and queue any replay it causes
  task automatic absorb_rx_byte(input logic [BYTE_W-1:0] b);
    frame_word_t w;
    case (b)
      CH_OPEN: begin
        line_open    = 1'b1;
        escape_armed = 1'b0;
        stored_len   = '0;
      end
      CH_CLOSE: begin
        if (line_open) begin
          line_open = 1'b0;
          if (stored_len == 0) begin
            w       = '0;
            w.empty = 1'b1;
            w.last  = 1'b1;
            replay_q = {replay_q, w};
          end else begin
            for (int i = 0; i < int'(stored_len); i++) begin
              w.payload = payload_mem[i];
              w.index   = IDX_W'(i);
              w.length  = LEN_W'(stored_len);
              w.empty   = 1'b0;
              w.last    = (i + 1 == int'(stored_len));
              replay_q = {replay_q, w};
            end
          end
        end
      end
      CH_ABORT: line_open = 1'b0;
      CH_ESC:   escape_armed = 1'b1;
      default: begin
        if (line_open) begin
          if (stored_len >= CNT_W'(MSG_BYTES)) begin
            // Store full: drop the frame, keep the escape mark
            line_open = 1'b0;
          end else begin
            payload_mem[stored_len[ADDR_W-1:0]] = escape_armed ? ~b : b;
            escape_armed = 1'b0;
            stored_len   = stored_len + CNT_W'(1);
          end
        end
      end
    endcase
  endtask

  // Compare one accepted result word with the oldest expected one
  task automatic check_word();
    frame_word_t got;
    frame_word_t want;
    got = '{res_i.payload_byte, res_i.byte_index, res_i.frame_length,
            res_i.empty_frame, res_i.last_in_frame};
    if (replay_q.size() == 0) begin
      $display("%0t: unexpected word, got %h/%0d/%0d/%b/%b", $time, got.payload,
               got.index, got.length, got.empty, got.last);
      fail_count_o++;
    end else begin
      want = replay_q.pop_front();
      if (got.payload != want.payload) begin
        $display("%0t: payload_byte expected %h, got %h", $time, want.payload, got.payload);
        fail_count_o++;
      end
      if (got.index != want.index) begin
        $display("%0t: byte_index expected %0d, got %0d", $time, want.index, got.index);
        fail_count_o++;
      end
      if (got.length != want.length) begin
        $display("%0t: frame_length expected %0d, got %0d", $time, want.length, got.length);
        fail_count_o++;
      end
      if (got.empty != want.empty) begin
        $display("%0t: empty_frame expected %b, got %b", $time, want.empty, got.empty);
        fail_count_o++;
      end
      if (got.last != want.last) begin
        $display("%0t: last_in_frame expected %b, got %b", $time, want.last, got.last);
        fail_count_o++;
      end
    end
  endtask

  // Watch both channels; take the input side before the result side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_open    = 1'b0;
      escape_armed = 1'b0;
      stored_len   = '0;
      replay_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (rx_i.valid && rx_i.ready) absorb_rx_byte(rx_i.rx_byte);
      if (res_i.valid && res_i.ready) check_word();
      pending_o = replay_q.size();
    end
  end

endmodule

>>> tb/escaped_frame_deframer_test.sv
module escaped_frame_deframer_test;

  timeunit 1ns;
  timeprecision 1ps;

  import efd_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        calm_tail;
  int unsigned fail_count;
  int unsigned pending_words;
  int unsigned bytes_sent;

  efd_rx_if  rx_if ();
  efd_res_if res_if ();

  escaped_frame_deframer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .res_o  (res_if)
  );

  efd_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_i         (rx_if),
    .res_i        (res_if),
    .fail_count_o (fail_count),
    .pending_o    (pending_words)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs
  initial begin
    #2ms;
    $display("Test completed with failures");
    $finish;
  end

  // Stall the result side in random bursts, none in the tail
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!calm_tail && $urandom_range(0, 5) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
    end
  end

  // Send one byte, then maybe idle for a burst
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    rx_if.rx_byte <= b;
    rx_if.valid   <= 1'b1;
    do @(posedge clk_i); while (!rx_if.ready);
    bytes_sent++;
    if (!calm_tail && $urandom_range(0, 3) == 0) begin
      rx_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  // Hold the sender until every replayed word has come back
  task automatic drain_words();
    rx_if.valid <= 1'b0;
    @(posedge clk_i);
    wait (pending_words == 0);
    @(posedge clk_i);
  endtask

  function automatic logic [BYTE_W-1:0] pick_data();
    logic [BYTE_W-1:0] b;
    do b = BYTE_W'($urandom_range(0, 255));
    while (b == CH_OPEN || b == CH_CLOSE || b == CH_ABORT || b == CH_ESC);
    return b;
  endfunction

  // Line noise, weighted toward the control characters
  function automatic logic [BYTE_W-1:0] pick_line_byte();
    case ($urandom_range(0, 7))
      0:       return CH_OPEN;
      1:       return CH_CLOSE;
      2:       return CH_ABORT;
      3:       return CH_ESC;
      default: return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Send a payload body, escaping some of the bytes
  task automatic send_body(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 3) == 0) send_byte(CH_ESC);
      send_byte(pick_data());
    end
  endtask

  // Send a payload body of plain data bytes only
  task automatic send_plain_body(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_byte(pick_data());
  endtask

  task automatic send_frame(input int unsigned len);
    send_byte(CH_OPEN);
    send_body(len);
    send_byte(CH_CLOSE);
  endtask

  initial begin
    int unsigned random_start;
    rst_ni        = 1'b0;
    calm_tail     = 1'b0;
    bytes_sent    = 0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Close and data outside a frame, escape outside cleared by open
    send_byte(CH_CLOSE);
    send_byte(8'h41);
    send_byte(CH_ESC);
    send_byte(CH_OPEN);
    send_byte(8'h00);
    send_byte(CH_ESC);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CH_ESC);
    send_byte(8'hFF);
    send_byte(CH_ESC);
    send_byte(CH_ESC);
    send_byte(8'h12);
    send_byte(CH_CLOSE);
    // Empty frame
    send_byte(CH_OPEN);
    send_byte(CH_CLOSE);
    // Abort, then a stray close
    send_byte(CH_OPEN);
    send_byte(8'h33);
    send_byte(CH_ABORT);
    send_byte(CH_CLOSE);
    // Controls still act with an escape pending
    send_byte(CH_OPEN);
    send_byte(CH_ESC);
    send_byte(CH_OPEN);
    send_byte(8'h80);
    send_byte(CH_ESC);
    send_byte(CH_CLOSE);
    drain_words();

    // Short clean frames, some noise and broken frames
    random_start = bytes_sent;
    while (bytes_sent < random_start + 12) begin
      case ($urandom_range(0, 9))
        0: repeat ($urandom_range(1, 4)) send_byte(pick_line_byte());
        1: begin
          send_byte(CH_OPEN);
          send_body($urandom_range(0, 5));
          send_byte($urandom_range(0, 1) ? CH_ABORT : CH_OPEN);
          if ($urandom_range(0, 1)) send_byte(CH_CLOSE);
        end
        default: send_frame($urandom_range(0, 8));
      endcase
    end

    // Full store replayed as one long run
    send_byte(CH_OPEN);
    send_plain_body(MSG_BYTES);
    send_byte(CH_CLOSE);

    // No idling from here on; one byte past a full store drops the frame
    calm_tail = 1'b1;
    send_byte(CH_OPEN);
    send_plain_body(MSG_BYTES);
    send_byte(CH_ESC);
    send_byte(pick_data());
    send_byte(CH_CLOSE);
    send_frame(2);

    drain_words();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
